/* rtl/dtc_pkg.sv */
// Package for the diagnostic trouble code table.
// Holds the operation codes, request/result structs, controller types and the
// supported-code ROM. Depends on nothing.
package dtc_pkg;

  // Operation selected by the func field of a request.
  typedef enum logic [2:0] {
    FUNC_REPORT      = 3'd0,
    FUNC_CLEAR_FAULT = 3'd1,
    FUNC_CLEAR_ALL   = 3'd2,
    FUNC_CLEAR_GROUP = 3'd3,
    FUNC_COUNT       = 3'd4,
    FUNC_READ_ALL    = 3'd5,
    FUNC_READ_STATUS = 3'd6,
    FUNC_READ_SUPP   = 3'd7
  } func_e;

  // Result codes.
  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_INVALID = 2'd1,
    RC_FULL    = 2'd2
  } rc_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_STREAM,
    ST_ROM,
    ST_FINISH
  } state_e;

  localparam int CODE_W  = 24;
  localparam int CNT_W   = 7;
  localparam int ROM_SIZE = 12;
  localparam logic [7:0] CLEAR_FAULT_BITS = 8'h47;

  typedef struct packed {
    logic [2:0]       func;
    logic [31:0]      fault_code;
    logic [7:0]       status_bits;
    logic [7:0]       group_id;
    logic [CNT_W-1:0] max_records;
  } req_t;

  typedef struct packed {
    logic [1:0]        result_code;
    logic [CNT_W-1:0]  match_count;
    logic [CODE_W-1:0] rec_code;
    logic [7:0]        rec_status;
    logic [15:0]       rec_occurrence;
    logic              rec_valid;
    logic              last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic stream;
    logic rom;
    logic finish;
    logic rewind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic to_rom;
    logic to_finish;
    logic scan_done;
    logic read_op;
    logic total_zero;
    logic stream_done;
    logic rom_done;
  } sts_t;

  // Supported codes, in reporting order.
  function automatic logic [CODE_W-1:0] rom_code(input logic [3:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      4'd0:    c = 24'hB10105;
      4'd1:    c = 24'hB10106;
      4'd2:    c = 24'hB10206;
      4'd3:    c = 24'hB10207;
      4'd4:    c = 24'hB10307;
      4'd5:    c = 24'hB10308;
      4'd6:    c = 24'hB10408;
      4'd7:    c = 24'hB10409;
      4'd8:    c = 24'hB10501;
      4'd9:    c = 24'hB10502;
      4'd10:   c = 24'hB10601;
      4'd11:   c = 24'hB10602;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/dtc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the record store. Depends on nothing.
module dtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dtc_ctrl.sv */
// Controller state machine for the trouble code table.
// Sequences dispatch, table scans, record streaming and the final result.
// Depends on dtc_pkg.
module dtc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  dtc_pkg::sts_t sts_i,
  output dtc_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  dtc_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtc_pkg::ST_IDLE: begin
        if (accept_i) state_d = dtc_pkg::ST_DISPATCH;
      end
      dtc_pkg::ST_DISPATCH: begin
        if (sts_i.to_rom) state_d = dtc_pkg::ST_ROM;
        else if (sts_i.to_finish) state_d = dtc_pkg::ST_FINISH;
        else state_d = dtc_pkg::ST_SCAN;
      end
      dtc_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.read_op && !sts_i.total_zero) state_d = dtc_pkg::ST_STREAM;
          else state_d = dtc_pkg::ST_FINISH;
        end
      end
      dtc_pkg::ST_STREAM: begin
        if (sts_i.stream_done) state_d = dtc_pkg::ST_IDLE;
      end
      dtc_pkg::ST_ROM: begin
        if (sts_i.rom_done) state_d = dtc_pkg::ST_IDLE;
      end
      dtc_pkg::ST_FINISH: begin
        state_d = dtc_pkg::ST_IDLE;
      end
      default: state_d = dtc_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      dtc_pkg::ST_IDLE:     cmd_o.load   = accept_i;
      dtc_pkg::ST_DISPATCH: cmd_o        = '0;
      dtc_pkg::ST_SCAN: begin
        cmd_o.scan   = !sts_i.scan_done;
        cmd_o.rewind = sts_i.scan_done;
      end
      dtc_pkg::ST_STREAM:   cmd_o.stream = 1'b1;
      dtc_pkg::ST_ROM:      cmd_o.rom    = 1'b1;
      dtc_pkg::ST_FINISH:   cmd_o.finish = 1'b1;
      default:              cmd_o        = '0;
    endcase
  end

  assign busy_o = (state_q != dtc_pkg::ST_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/dtc_datapath.sv */
// Datapath for the trouble code table: record RAM, scan pipeline, counters
// and the result register. Depends on dtc_pkg and dtc_ram.
module dtc_datapath #(
  parameter int DEPTH = 64,
  parameter int OCC_W = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dtc_pkg::req_t req_i,
  input  dtc_pkg::cmd_t cmd_i,
  output dtc_pkg::sts_t sts_o,
  output logic          res_valid_o,
  output dtc_pkg::rsp_t res_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = dtc_pkg::CODE_W + 8 + OCC_W;
  localparam int CW = dtc_pkg::CNT_W;

  // Request fields held for the whole operation.
  dtc_pkg::req_t req_q;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pv_q, pv_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] k_q, k_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  logic [RW-1:0] hit_rec_q, hit_rec_d;
  logic          res_valid_q, res_valid_d;
  dtc_pkg::rsp_t res_q, res_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [RW-1:0] wdata;
  logic [RW-1:0] rdata;

  logic [dtc_pkg::CODE_W-1:0] rd_code;
  logic [7:0]                 rd_st;
  logic [OCC_W-1:0]           rd_occ;
  logic [dtc_pkg::CODE_W-1:0] h_code;
  logic [7:0]                 h_st;
  logic [OCC_W-1:0]           h_occ;

  dtc_pkg::func_e func;
  logic           code_ok;
  logic           stop_op;
  logic           read_op;
  logic           sel;
  logic           issue;
  logic [CW-1:0]  rom_total;

  dtc_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign {rd_code, rd_st, rd_occ} = rdata;
  assign {h_code, h_st, h_occ}    = hit_rec_q;

  // Decoded operation properties.
  assign func    = dtc_pkg::func_e'(req_q.func);
  assign code_ok = (req_q.fault_code != 32'd0) && (req_q.fault_code[31:24] == 8'd0);
  assign stop_op = (func == dtc_pkg::FUNC_REPORT) || (func == dtc_pkg::FUNC_CLEAR_FAULT);
  assign read_op = (func == dtc_pkg::FUNC_READ_ALL) || (func == dtc_pkg::FUNC_READ_STATUS);
  assign sel     = (func == dtc_pkg::FUNC_READ_ALL) || ((rd_st & req_q.status_bits) != 8'd0);
  assign issue   = (idx_q < fill_q) && !(stop_op && hit_q);
  assign rom_total = (req_i.max_records < CW'(dtc_pkg::ROM_SIZE)) ?
                     req_i.max_records : CW'(dtc_pkg::ROM_SIZE);

  // Status to the controller.
  always_comb begin
    sts_o.to_rom      = (func == dtc_pkg::FUNC_READ_SUPP) && (total_q != '0);
    sts_o.to_finish   = (func == dtc_pkg::FUNC_CLEAR_ALL) ||
                        (func == dtc_pkg::FUNC_READ_SUPP) ||
                        (stop_op && !code_ok);
    sts_o.scan_done   = (stop_op && hit_q) || ((idx_q >= fill_q) && !pv_q);
    sts_o.read_op     = read_op;
    sts_o.total_zero  = (total_q == '0);
    sts_o.stream_done = (k_q == total_q);
    sts_o.rom_done    = (k_q == total_q);
  end

  // Scan, stream and finish logic.
  always_comb begin
    fill_d      = fill_q;
    idx_d       = idx_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    wr_d        = wr_q;
    total_d     = total_q;
    k_d         = k_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_rec_d   = hit_rec_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    we          = 1'b0;
    waddr       = wr_q[AW-1:0];
    wdata       = rdata;

    if (cmd_i.load) begin
      idx_d   = '0;
      wr_d    = '0;
      k_d     = '0;
      hit_d   = 1'b0;
      total_d = (dtc_pkg::func_e'(req_i.func) == dtc_pkg::FUNC_READ_SUPP) ? rom_total : '0;
    end else if (cmd_i.rewind) begin
      idx_d = '0;
      k_d   = '0;
    end else if (cmd_i.scan || cmd_i.stream) begin
      // Issue the next read; its data comes back in the following cycle.
      if (issue) begin
        pv_d   = 1'b1;
        pidx_d = idx_q[AW-1:0];
        idx_d  = idx_q + 1'b1;
      end
      if (pv_q && cmd_i.scan) begin
        case (func) inside
          dtc_pkg::FUNC_REPORT, dtc_pkg::FUNC_CLEAR_FAULT: begin
            if (!hit_q && (rd_code == req_q.fault_code[dtc_pkg::CODE_W-1:0])) begin
              hit_d     = 1'b1;
              hit_idx_d = pidx_q;
              hit_rec_d = rdata;
            end
          end
          dtc_pkg::FUNC_CLEAR_GROUP: begin
            if (rd_code[23:16] != req_q.group_id) begin
              we   = 1'b1;
              wr_d = wr_q + 1'b1;
            end
          end
          dtc_pkg::FUNC_COUNT: begin
            if ((rd_st & req_q.status_bits) != 8'd0) total_d = total_q + 1'b1;
          end
          dtc_pkg::FUNC_READ_ALL, dtc_pkg::FUNC_READ_STATUS: begin
            if (sel && (total_q < req_q.max_records)) total_d = total_q + 1'b1;
          end
          default: ;
        endcase
      end
      // Second pass of a read: one result per selected record.
      if (pv_q && cmd_i.stream && sel && (k_q < total_q)) begin
        res_valid_d          = 1'b1;
        res_d.result_code    = dtc_pkg::RC_OK;
        res_d.match_count    = total_q;
        res_d.rec_code       = rd_code;
        res_d.rec_status     = rd_st;
        res_d.rec_occurrence = 16'(rd_occ);
        res_d.rec_valid      = 1'b1;
        res_d.last           = (k_q + 1'b1 == total_q);
        k_d                  = k_q + 1'b1;
      end
    end else if (cmd_i.rom) begin
      if (k_q < total_q) begin
        res_valid_d       = 1'b1;
        res_d.match_count = total_q;
        res_d.rec_code    = dtc_pkg::rom_code(k_q[3:0]);
        res_d.rec_valid   = 1'b1;
        res_d.last        = (k_q + 1'b1 == total_q);
        k_d               = k_q + 1'b1;
      end
    end else if (cmd_i.finish) begin
      res_valid_d       = 1'b1;
      res_d.match_count = total_q;
      res_d.last        = 1'b1;
      case (func)
        dtc_pkg::FUNC_REPORT: begin
          if (!code_ok) begin
            res_d.result_code = dtc_pkg::RC_INVALID;
          end else if (hit_q) begin
            we    = 1'b1;
            waddr = hit_idx_q;
            wdata = {h_code, req_q.status_bits, h_occ + 1'b1};
          end else if (fill_q >= CW'(DEPTH)) begin
            res_d.result_code = dtc_pkg::RC_FULL;
          end else begin
            we     = 1'b1;
            waddr  = fill_q[AW-1:0];
            wdata  = {req_q.fault_code[dtc_pkg::CODE_W-1:0], req_q.status_bits,
                      OCC_W'(1)};
            fill_d = fill_q + 1'b1;
          end
        end
        dtc_pkg::FUNC_CLEAR_FAULT: begin
          if (!code_ok) begin
            res_d.result_code = dtc_pkg::RC_INVALID;
          end else if (hit_q) begin
            we    = 1'b1;
            waddr = hit_idx_q;
            wdata = {h_code, h_st & ~dtc_pkg::CLEAR_FAULT_BITS, h_occ};
          end
        end
        dtc_pkg::FUNC_CLEAR_ALL:   fill_d = '0;
        dtc_pkg::FUNC_CLEAR_GROUP: fill_d = wr_q;
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      idx_q       <= '0;
      pv_q        <= 1'b0;
      wr_q        <= '0;
      total_q     <= '0;
      k_q         <= '0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      pv_q        <= pv_d;
      wr_q        <= wr_d;
      total_q     <= total_d;
      k_q         <= k_d;
      hit_q       <= hit_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    pidx_q    <= pidx_d;
    hit_idx_q <= hit_idx_d;
    hit_rec_q <= hit_rec_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/diagnostic_trouble_code_table.sv */
// Top level of the diagnostic trouble code table.
// Joins the controller (dtc_ctrl) and the datapath (dtc_datapath); uses dtc_pkg.
//
//   channel  | ports                          | transfer
//   ---------+--------------------------------+-------------------------------
//   request  | start_i, busy_o, req_i         | start_i high while busy_o low
//   result   | result_valid_o, result_o       | one cycle per result strobe
//
// After the accepting edge a request passes a dispatch state, and each table
// scan then reads the records over the single RAM read port. A report,
// clear or count then passes a finish state and its result follows; an
// invalid code or clear all goes straight to finish. A read scans twice and
// streams its records in the second pass; read supported streams from the
// code ROM. Reset clears the fill level, so the table starts empty with no
// clearing pass. The receiver cannot stall; busy_o holds off new requests.
module diagnostic_trouble_code_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int OCC_WIDTH   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dtc_pkg::req_t req_i,
  output logic          result_valid_o,
  output dtc_pkg::rsp_t result_o
);

  dtc_pkg::cmd_t cmd;
  dtc_pkg::sts_t sts;
  logic          ctrl_busy;
  logic          accept;

  // A request is taken only when no work and no result is outstanding.
  assign busy_o = ctrl_busy | result_valid_o;
  assign accept = start_i & ~busy_o;

  dtc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  dtc_datapath #(.DEPTH(TABLE_DEPTH), .OCC_W(OCC_WIDTH)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(result_valid_o),
    .res_o      (result_o)
  );

endmodule

/* rtl/dtc_checker.sv */
// Port-level checker for the trouble code table, bound to the top level.
// Depends on dtc_pkg.
module dtc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          result_valid_o,
  input dtc_pkg::rsp_t result_o
);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after request");

  // Results only appear while the block reports busy.
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result while idle");

  // The final result of a request is not followed at once by another one.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |=> !result_valid_o)
    else $error("result right after last");

  // A result without a record is always the only and final one.
  a_norec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.rec_valid |-> result_o.last)
    else $error("record-less result not last");

  // Streamed records always carry an ok result code.
  a_rec_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.rec_valid |-> result_o.result_code == dtc_pkg::RC_OK)
    else $error("record with error code");

endmodule

bind diagnostic_trouble_code_table dtc_checker u_dtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
